// ===== rtl/core/wusd_pkg.sv =====
`default_nettype none

package wusd_pkg;

    // build-time configuration
    localparam int NUM_WINDOWS  = 4;
    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_BITS  = 16;

    // fixed field widths of the interface
    localparam int NUM_LEN_REGS = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int LEN_W        = 7;
    localparam int SEL_W        = 2;
    localparam int SMP_FIELD_W  = 16;
    localparam int STD_W        = 24;
    localparam int FRAC_W       = 16;

    // derived widths
    localparam int WIN_W     = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int N_W       = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W    = $clog2(NUM_WINDOWS * WINDOW_MAX);
    localparam int S_W       = SAMPLE_BITS + N_W;
    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam int Q_W       = SQ_W + N_W;
    localparam int D_W       = Q_W + N_W;
    localparam int M_W       = 2 * N_W;
    localparam int DV_W      = D_W + FRAC_W;
    localparam int RT_IN_W   = 2 * STD_W;
    localparam int QX_W      = (DV_W > RT_IN_W) ? DV_W : RT_IN_W + 1;
    localparam int RR_W      = STD_W + 2;
    localparam int DV_CNT_W  = $clog2(DV_W + 1);
    localparam int RT_CNT_W  = $clog2(STD_W + 1);

    localparam logic [STD_W-1:0] STD_MAX = '1;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                   command;
        logic [SEL_W-1:0]       window_select;
        logic [SMP_FIELD_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [STD_W-1:0] std_dev;
        logic             window_ready;
    } t_out_item;

    // window length saturated to the ring depth
    function automatic logic [N_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [N_W-1:0] res;
        if (int'(len) > WINDOW_MAX) begin
            res = N_W'(WINDOW_MAX);
        end else begin
            res = N_W'(len);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wusd_sample_ram.sv =====
`default_nettype none

module wusd_sample_ram (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [wusd_pkg::ADDR_W-1:0]     i_waddr,
    input  wire logic [wusd_pkg::SAMPLE_BITS-1:0] i_wdata,
    input  wire logic [wusd_pkg::ADDR_W-1:0]     i_raddr,
    output logic      [wusd_pkg::SAMPLE_BITS-1:0] o_rdata
);
    import wusd_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [NUM_WINDOWS*WINDOW_MAX];

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/wusd_divider.sv =====
`default_nettype none

module wusd_divider (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [wusd_pkg::DV_W-1:0] i_dividend,
    input  wire logic [wusd_pkg::M_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic      [wusd_pkg::DV_W-1:0] o_quotient
);
    import wusd_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DV_CNT_W-1:0] r_cnt;
    logic [M_W-1:0]      r_div;
    logic [M_W-1:0]      r_rem;
    logic [DV_W-1:0]     r_quo;

    logic [M_W:0]        trial;
    logic                fits;
    logic [M_W:0]        diff;

    // one restoring step per cycle
    always_comb begin
        trial = {r_rem, r_quo[DV_W-1]};
        fits  = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DV_CNT_W'(DV_W);
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= fits ? diff[M_W-1:0] : trial[M_W-1:0];
                r_quo <= {r_quo[DV_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/wusd_isqrt.sv =====
`default_nettype none

module wusd_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wusd_pkg::RT_IN_W-1:0] i_value,
    output logic                             o_done,
    output logic      [wusd_pkg::STD_W-1:0]   o_root
);
    import wusd_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [RT_CNT_W-1:0] r_cnt;
    logic [RT_IN_W-1:0]  r_val;
    logic [RR_W-1:0]     r_rem;
    logic [STD_W-1:0]    r_root;

    logic [RR_W-1:0]     rem_sh;
    logic [RR_W-1:0]     trial;
    logic                fits;

    // bring down two bits, try root*4+1
    always_comb begin
        rem_sh = {r_rem[RR_W-3:0], r_val[RT_IN_W-1:RT_IN_W-2]};
        trial  = {r_root, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= RT_CNT_W'(STD_W);
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[RT_IN_W-3:0], 2'b00};
                r_rem  <= fits ? rem_sh - trial : rem_sh;
                r_root <= {r_root[STD_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == RT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== rtl/core/windowed_unbiased_std_dev_core.sv =====
// Sliding-window sample standard deviation over several ring windows.
// Input channel (i_in_valid / o_in_ready, i_in_item): a sample command stores
// sample_value in the window chosen by window_select; a clear command rewinds
// every window and empties its data. Every item gives exactly one result item
// on the output channel (o_out_valid / i_out_ready, o_out_item).
// Config channel (i_cfg_valid / o_cfg_ready, always ready): i_cfg_index picks
// window_len_a..d, i_cfg_data is the 7-bit length; write only while idle.
// An item that needs no statistic (clear, disabled or unwrapped window) goes
// straight to the done state and is answered from there. A wrapped window of
// length n walks its samples through the memory read port, then runs the
// bit-serial divider and after it the bit-serial square root.
// One item is in work at a time; o_in_ready is high only between items, so a
// new item can be taken once the previous result is registered.
// The result sits in an output register, so a new item is taken while the
// receiver stalls; a second result then waits until the first is taken.
// Reset clears lengths, write positions, fill marks and wrapped marks; sample
// memory is not cleared, entries at or beyond a window's fill mark read as 0.
`default_nettype none

module windowed_unbiased_std_dev_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire wusd_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output wusd_pkg::t_out_item                o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [wusd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wusd_pkg::LEN_W-1:0]     i_cfg_data
);
    import wusd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MUL,
        S_DIV_START,
        S_DIVIDE,
        S_ROOT,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration and window control
    logic [LEN_W-1:0]       r_len [NUM_LEN_REGS];
    logic [N_W-1:0]         r_pos [NUM_WINDOWS];
    logic [N_W-1:0]         r_fill [NUM_WINDOWS];
    logic [NUM_WINDOWS-1:0] r_wrapped;

    // statistic datapath
    logic [ADDR_W-1:0]      r_base;
    logic [N_W-1:0]         r_n;
    logic [N_W-1:0]         r_fillw;
    logic [N_W-1:0]         r_cnt;
    logic                   r_rd_vld;
    logic                   r_rd_zero;
    logic                   r_a_vld;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [SQ_W-1:0]        r_sq;
    logic [S_W-1:0]         r_s;
    logic [Q_W-1:0]         r_q;
    logic [D_W-1:0]         r_nq;
    logic [D_W-1:0]         r_ss;
    logic [M_W-1:0]         r_m;
    logic                   r_sat;
    t_out_item              r_res;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   in_acc;
    logic                   sel_ok;
    logic [WIN_W-1:0]       sel_idx;
    logic [N_W-1:0]         len_now;
    logic                   len_ok;
    logic [N_W-1:0]         cur_pos;
    logic                   wrap_now;
    logic [N_W-1:0]         wr_pos;
    logic [N_W-1:0]         fill_now;
    logic                   ready_now;
    logic                   do_store;
    logic [ADDR_W-1:0]      base;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    logic                   issue;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] rd_val;
    logic [D_W-1:0]         d_val;
    logic                   div_start;
    logic                   div_done;
    logic [DV_W-1:0]        quotient;
    logic [QX_W-1:0]        q_ext;
    logic                   rt_done;
    logic [STD_W-1:0]       root;
    logic                   out_free;

    // decode of the item at the input
    always_comb begin
        in_acc    = i_in_valid && o_in_ready;
        sel_ok    = int'(i_in_item.window_select) < NUM_WINDOWS;
        sel_idx   = WIN_W'(i_in_item.window_select);
        len_now   = sat_len(r_len[i_in_item.window_select]);
        len_ok    = len_now >= N_W'(2);
        cur_pos   = r_pos[sel_idx];
        wrap_now  = cur_pos >= len_now;
        wr_pos    = wrap_now ? '0 : cur_pos;
        fill_now  = (wr_pos >= r_fill[sel_idx]) ? wr_pos + 1'b1 : r_fill[sel_idx];
        ready_now = wrap_now || r_wrapped[sel_idx];
        do_store  = in_acc && (i_in_item.command == CMD_SAMPLE) && sel_ok && len_ok;
        base      = ADDR_W'(sel_idx) * ADDR_W'(WINDOW_MAX);
        waddr     = base + ADDR_W'(wr_pos);
    end

    // read walk over the window
    always_comb begin
        issue = (r_state == S_ACC) && (r_cnt < r_n);
        raddr = r_base + ADDR_W'(r_cnt);
    end

    wusd_sample_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (do_store),
        .i_waddr (waddr),
        .i_wdata (SAMPLE_BITS'(i_in_item.sample_value)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // entries past the fill mark count as zero
    assign rd_val = r_rd_zero ? '0 : rdata;

    // n*q - s*s, scaled for the fraction bits
    always_comb begin
        d_val     = r_nq - r_ss;
        div_start = (r_state == S_DIV_START);
    end

    wusd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({d_val, {FRAC_W{1'b0}}}),
        .i_divisor  (r_m),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign q_ext = QX_W'(quotient);

    wusd_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_done),
        .i_value (q_ext[RT_IN_W-1:0]),
        .o_done  (rt_done),
        .o_root  (root)
    );

    assign out_free = !r_out_valid || i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEN_REGS; i++) begin
                r_len[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            r_len[i_cfg_index] <= i_cfg_data;
        end
    end

    // sequencer, window control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wrapped   <= '0;
            r_rd_vld    <= 1'b0;
            r_a_vld     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                r_pos[i]  <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    r_a_vld  <= 1'b0;
                    r_cnt    <= '0;
                    r_s      <= '0;
                    r_q      <= '0;
                    r_res    <= '0;
                    if (in_acc) begin
                        r_state <= S_DONE;
                        if (i_in_item.command == CMD_CLEAR) begin
                            r_wrapped <= '0;
                            for (int i = 0; i < NUM_WINDOWS; i++) begin
                                r_pos[i]  <= '0;
                                r_fill[i] <= '0;
                            end
                        end else if (do_store) begin
                            r_pos[sel_idx]  <= wr_pos + 1'b1;
                            r_fill[sel_idx] <= fill_now;
                            if (wrap_now) begin
                                r_wrapped[sel_idx] <= 1'b1;
                            end
                            if (ready_now) begin
                                r_base  <= base;
                                r_n     <= len_now;
                                r_fillw <= fill_now;
                                r_state <= S_ACC;
                            end
                        end
                    end
                end
                S_ACC: begin
                    // issue, square, accumulate
                    r_rd_vld  <= issue;
                    r_rd_zero <= r_cnt >= r_fillw;
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_a_vld <= r_rd_vld;
                    if (r_rd_vld) begin
                        r_x  <= rd_val;
                        r_sq <= SQ_W'(rd_val) * SQ_W'(rd_val);
                    end
                    if (r_a_vld) begin
                        r_s <= r_s + S_W'(r_x);
                        r_q <= r_q + Q_W'(r_sq);
                    end
                    if (!issue && !r_rd_vld && !r_a_vld) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_nq    <= D_W'(r_n) * D_W'(r_q);
                    r_ss    <= D_W'(r_s) * D_W'(r_s);
                    r_m     <= M_W'(r_n) * M_W'(r_n - 1'b1);
                    r_state <= S_DIV_START;
                end
                S_DIV_START: begin
                    r_state <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    if (div_done) begin
                        r_sat   <= |q_ext[QX_W-1:RT_IN_W];
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (rt_done) begin
                        r_res.std_dev      <= r_sat ? STD_MAX : root;
                        r_res.window_ready <= 1'b1;
                        r_state            <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_item  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/wusd_checker.sv =====
`default_nettype none

module wusd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire wusd_pkg::t_out_item           o_out_item
);
    import wusd_pkg::*;

    // a result without a wrapped window carries no deviation
    a_zero_when_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.window_ready |-> o_out_item.std_dev == '0)
        else $error("std_dev nonzero while window_ready is low");

    // one item in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken twice in a row");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    // nothing is offered straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind windowed_unbiased_std_dev_core wusd_checker u_wusd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== verif/windowed_unbiased_std_dev_core_tb.sv =====
`default_nettype none

module windowed_unbiased_std_dev_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wusd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 3;
    localparam int TAIL_CYCLES  = 200;
    localparam int MAX_PRINTED  = 200;

    // register indexes of the length registers
    typedef enum int {
        REG_LEN_A,
        REG_LEN_B,
        REG_LEN_C,
        REG_LEN_D
    } len_reg_e;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_item   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out_item;
    logic                 o_cfg_ready;

    windowed_unbiased_std_dev_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow of the block state
    logic [LEN_W-1:0]       cfg_len      [NUM_LEN_REGS];
    logic [SAMPLE_BITS-1:0] ring_store   [NUM_WINDOWS][WINDOW_MAX];
    int unsigned            write_pos    [NUM_WINDOWS];
    bit                     wrapped      [NUM_WINDOWS];
    // entries written since the last clear, always a prefix of the ring
    int unsigned            fill_depth   [NUM_WINDOWS];

    t_in_item         pending_commands[$];
    t_out_item        expected_reports[$];
    logic [LEN_W-1:0] new_len [NUM_LEN_REGS];
    logic [15:0]      sample_base   = '0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int unsigned      error_count   = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        // keep the log short if everything goes wrong
        if (error_count <= MAX_PRINTED) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    function automatic int unsigned clamp_len(input logic [LEN_W-1:0] v);
        return (int'(v) > WINDOW_MAX) ? WINDOW_MAX : int'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // updates the shadow state and returns the result the block should give
    function automatic t_out_item predict_std_dev(input t_in_item cmd);
        t_out_item   res;
        int unsigned w;
        int unsigned n;
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] root;
        res = '0;
        // clear wipes data, positions and wrapped marks
        if (cmd.command == CMD_CLEAR) begin
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                for (int j = 0; j < WINDOW_MAX; j++) begin
                    ring_store[i][j] = '0;
                end
                write_pos[i]  = 0;
                wrapped[i]    = 1'b0;
                fill_depth[i] = 0;
            end
            return res;
        end
        w = cmd.window_select;
        if (w >= NUM_WINDOWS || w >= NUM_LEN_REGS) begin
            return res;
        end
        n = clamp_len(cfg_len[w]);
        if (n < 2) begin
            return res;
        end
        // store the sample, wrapping first if the ring is full
        if (write_pos[w] >= n) begin
            write_pos[w] = 0;
            wrapped[w]   = 1'b1;
        end
        ring_store[w][write_pos[w]] = cmd.sample_value[SAMPLE_BITS-1:0];
        write_pos[w]++;
        if (write_pos[w] > fill_depth[w]) begin
            fill_depth[w] = write_pos[w];
        end
        if (!wrapped[w]) begin
            return res;
        end
        // exact unbiased variance, then root in q16.8
        s = '0;
        q = '0;
        for (int i = 0; i < n; i++) begin
            x = 64'(ring_store[w][i]);
            s += x;
            q += x * x;
        end
        d   = 64'(n) * q - s * s;
        m   = 64'(n) * 64'(n - 1);
        quo = d / m;
        rem = d % m;
        if (quo >= (64'd1 << 32)) begin
            res.std_dev = STD_MAX;
        end else begin
            root = int_sqrt((quo << 16) + ((rem << 16) / m));
            res.std_dev = (root > 64'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
        end
        res.window_ready = 1'b1;
        return res;
    endfunction

    function automatic t_in_item make_cmd(input logic c, input int unsigned sel,
                                          input int unsigned val);
        t_in_item cmd;
        cmd.command       = c;
        cmd.window_select = SEL_W'(sel);
        cmd.sample_value  = SMP_FIELD_W'(val);
        return cmd;
    endfunction

    // mostly samples to live windows, some noise and the odd clear
    function automatic t_in_item random_command(input int unsigned clear_permille);
        t_in_item    cmd;
        int unsigned roll;
        int unsigned pick;
        int unsigned w;
        bit          any_live;
        roll = $urandom_range(999);
        pick = $urandom_range(99);
        cmd.command       = (roll < clear_permille) ? CMD_CLEAR : CMD_SAMPLE;
        cmd.window_select = SEL_W'($urandom);
        any_live = 1'b0;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            if (clamp_len(cfg_len[i]) >= 2) begin
                any_live = 1'b1;
            end
        end
        if (roll >= 100 && any_live) begin
            w = $urandom_range(NUM_WINDOWS - 1);
            while (clamp_len(cfg_len[w]) < 2) begin
                w = $urandom_range(NUM_WINDOWS - 1);
            end
            cmd.window_select = SEL_W'(w);
        end
        if (pick < 40) begin
            cmd.sample_value = SMP_FIELD_W'($urandom);
        end else if (pick < 85) begin
            cmd.sample_value = sample_base + SMP_FIELD_W'($urandom_range(255));
        end else begin
            cmd.sample_value = (pick < 92) ? '0 : '1;
        end
        return cmd;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_commands.size() != 0 || i_in_valid || expected_reports.size() != 0);
    endtask

    // writes new_len to all four registers, clearing first if a wrapped
    // window would grow past the entries it has written
    task automatic apply_lengths();
        bit          needs_clear;
        int unsigned n;
        needs_clear = 1'b0;
        wait_idle();
        for (int w = 0; w < NUM_WINDOWS && w < NUM_LEN_REGS; w++) begin
            n = clamp_len(new_len[w]);
            if (wrapped[w] && n >= 2 && n > fill_depth[w]) begin
                needs_clear = 1'b1;
            end
        end
        if (needs_clear) begin
            pending_commands.push_back(make_cmd(CMD_CLEAR, $urandom, $urandom));
            wait_idle();
        end
        @(posedge i_clk);
        for (int r = REG_LEN_A; r <= REG_LEN_D; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data  <= new_len[r];
            do @(posedge i_clk);
            while (!o_cfg_ready);
            cfg_len[r] = new_len[r];
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] random_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return LEN_W'($urandom_range(1));
        end else if (roll < 20) begin
            return LEN_W'($urandom_range(127, WINDOW_MAX));
        end
        return LEN_W'($urandom_range(12, 2));
    endfunction

    // item driver
    always @(posedge i_clk) begin : drive_items
        logic next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                expected_reports.push_back(predict_std_dev(i_in_item));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_commands.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= pending_commands.pop_front();
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : check_reports
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected item std_dev=%0d ready=%0b",
                                              o_out_item.std_dev, o_out_item.window_ready));
                end else begin
                    want = expected_reports.pop_front();
                    if (o_out_item.std_dev !== want.std_dev) begin
                        report_mismatch($sformatf("std_dev got %0d want %0d",
                                                  o_out_item.std_dev, want.std_dev));
                    end
                    if (o_out_item.window_ready !== want.window_ready) begin
                        report_mismatch($sformatf("window_ready got %0b want %0b",
                                                  o_out_item.window_ready, want.window_ready));
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // stimulus
    initial begin : run_stimulus
        int unsigned phase_items;
        int unsigned clear_pm;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            for (int j = 0; j < WINDOW_MAX; j++) begin
                ring_store[i][j] = '0;
            end
            write_pos[i]  = 0;
            wrapped[i]    = 1'b0;
            fill_depth[i] = 0;
        end
        for (int r = REG_LEN_A; r <= REG_LEN_D; r++) begin
            cfg_len[r] = '0;
        end
        send_idle_pct = 6;
        recv_idle_pct = 77;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: two short windows, two disabled ones
        new_len = '{LEN_W'(2), LEN_W'(3), LEN_W'(0), LEN_W'(1)};
        apply_lengths();
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 0, 0));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 0, 65535));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 0, 0));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 0, 65535));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 1));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 2));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 3));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 4));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 4));
        // equal samples give zero deviation
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 4));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 2, 12345));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 3, 40000));
        pending_commands.push_back(make_cmd(CMD_CLEAR, 3, 65535));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 0, 16'h5555));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 0, 16'haaaa));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 0, 100));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 7));
        pending_commands.push_back(make_cmd(CMD_CLEAR, 0, 0));
        pending_commands.push_back(make_cmd(CMD_SAMPLE, 1, 65535));

        // random phases: full depth and saturated lengths first, then mixed
        for (int ph = 1; ph <= 6; ph++) begin
            wait_idle();
            if (ph <= 2) begin
                send_idle_pct = 6;
                recv_idle_pct = 77;
            end else if (ph <= 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 1) begin
                new_len     = '{LEN_W'(64), LEN_W'(127), LEN_W'(1), LEN_W'(0)};
                phase_items = 220;
                clear_pm    = 0;
            end else begin
                foreach (new_len[r]) begin
                    new_len[r] = random_len();
                end
                phase_items = 136;
                clear_pm    = 10;
            end
            apply_lengths();
            sample_base = 16'($urandom);
            for (int k = 0; k < phase_items; k++) begin
                // hold off the sender until the block has drained
                if (ph == 2 && k == phase_items / 2) begin
                    wait_idle();
                end
                pending_commands.push_back(random_command(clear_pm));
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS windowed_unbiased_std_dev_core");
        end else begin
            $display("FAIL windowed_unbiased_std_dev_core");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(60_000_000);
        $display("FAIL windowed_unbiased_std_dev_core");
        $finish;
    end

endmodule

`default_nettype wire

// ===== windowed_unbiased_std_dev_core.f =====
rtl/core/wusd_pkg.sv
rtl/core/wusd_sample_ram.sv
rtl/core/wusd_divider.sv
rtl/core/wusd_isqrt.sv
rtl/core/windowed_unbiased_std_dev_core.sv
rtl/core/wusd_checker.sv
verif/windowed_unbiased_std_dev_core_tb.sv
